// File: hdl/sle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the sequential list engine
// Opcodes, status codes, the entry layout and the command that the
// controller broadcasts to the row of list cells.
// ----------------------------------------------------------------------------
package sle_pkg;

  // default list depth and the widths that follow from it
  localparam int LIST_DEPTH_DEF = 16;
  localparam int CNT_W_DEF      = $clog2(LIST_DEPTH_DEF + 1);
  // widest position/count for the largest supported depth (256)
  localparam int MAX_CNT_W      = 9;

  // operation codes of an input beat
  typedef enum logic [2:0] {
    OP_CLEAR     = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_INS_BACK  = 3'd3,
    OP_REMOVE    = 3'd4,
    OP_FIND      = 3'd5
  } op_t;

  // status codes of a result beat
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_t;

  // one list entry
  typedef struct packed {
    logic [31:0] payload;
    logic [31:0] key;
  } entry_t;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic [MAX_CNT_W-1:0]   idx;
  } cell_cmd_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REPORT
  } state_t;

endpackage : sle_pkg
`default_nettype wire

// File: hdl/sle_intf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_intf: input and result channels of the sequential list engine
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sle_in_if #(
  parameter int CNT_W = sle_pkg::CNT_W_DEF
);
  logic                valid;
  logic                ready;
  logic [2:0]          operation;
  logic [CNT_W-1:0]    position;
  logic signed [31:0]  key;
  logic [31:0]         payload;

  modport source (output valid, operation, position, key, payload, input ready);
  modport sink   (input valid, operation, position, key, payload, output ready);
endinterface : sle_in_if

interface sle_out_if #(
  parameter int CNT_W = sle_pkg::CNT_W_DEF
);
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic                found;
  logic [CNT_W-1:0]    found_position;
  logic [31:0]         found_payload;
  logic [CNT_W-1:0]    entry_count;

  modport source (output valid, status, found, found_position, found_payload,
                  entry_count, input ready);
  modport sink   (input valid, status, found, found_position, found_payload,
                  entry_count, output ready);
endinterface : sle_out_if
`default_nettype wire

// File: hdl/sle_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_cell: one slot of the list
// Holds one entry at a fixed logical index and, on the broadcast command,
// keeps it, loads the new entry, or takes its left or right neighbor.
// ----------------------------------------------------------------------------
module sle_cell #(
  parameter int IDX = 0
) (
  input  wire                 clk,
  input  sle_pkg::cell_cmd_t  cmd,
  input  sle_pkg::entry_t     new_ent,
  input  sle_pkg::entry_t     left_ent,
  input  sle_pkg::entry_t     right_ent,
  output sle_pkg::entry_t     ent
);
  import sle_pkg::*;

  localparam logic [MAX_CNT_W-1:0] MY_IDX = MAX_CNT_W'(IDX);

  entry_t ent_r;
  entry_t ent_nxt;

  // slot update: insert opens a gap, remove closes one, rotate walks left
  always_comb begin
    ent_nxt = ent_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (MY_IDX == cmd.idx) begin
          ent_nxt = new_ent;
        end else if (MY_IDX > cmd.idx) begin
          ent_nxt = left_ent;
        end
      end
      CELL_REMOVE: begin
        if (MY_IDX >= cmd.idx) begin
          ent_nxt = right_ent;
        end
      end
      CELL_ROTATE: ent_nxt = right_ent;
      default:     ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule : sle_cell
`default_nettype wire

// File: hdl/sle_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_ctrl: sequencer of the sequential list engine
// Decodes each input beat into a cell command, tracks the list length,
// runs the find scan over the rotating row and holds the result beat.
// ----------------------------------------------------------------------------
module sle_ctrl #(
  parameter int LIST_DEPTH = sle_pkg::LIST_DEPTH_DEF,
  parameter int CNT_W      = sle_pkg::CNT_W_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  sle_in_if.sink               in_ch,
  sle_out_if.source            out_ch,
  input  sle_pkg::entry_t      head_ent,
  output sle_pkg::cell_cmd_t   cmd
);
  import sle_pkg::*;

  localparam int                STEP_W    = $clog2(LIST_DEPTH);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LIST_DEPTH - 1);
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(LIST_DEPTH);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   len_r, len_nxt;
  logic [STEP_W-1:0]  step_r;
  logic [31:0]        key_r;
  logic               hit_r;
  logic [CNT_W-1:0]   hpos_r;
  logic [31:0]        hpay_r;

  logic               out_valid_r;
  status_t            out_status_r;
  logic               out_found_r;
  logic [CNT_W-1:0]   out_fpos_r;
  logic [31:0]        out_fpay_r;
  logic [CNT_W-1:0]   out_cnt_r;

  logic               out_free;
  logic               in_fire;
  logic               full;
  logic               match;
  op_t                op;
  status_t            stat;
  logic [CNT_W:0]     pos_x;
  logic [CNT_W:0]     len_x;
  logic [CNT_W-1:0]   pos_m1;

  // handshake
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign op     = op_t'(in_ch.operation);
  assign full   = (len_r >= DEPTH_CNT);
  assign pos_x  = {1'b0, in_ch.position};
  assign len_x  = {1'b0, len_r};
  assign pos_m1 = in_ch.position - CNT_W'(1);

  // first match while the head cell walks through the list
  assign match = (state_r == S_SCAN) && !hit_r && (CNT_W'(step_r) < len_r) &&
                 (head_ent.key == key_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && op == OP_FIND) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (step_r == LAST_STEP) begin
          state_nxt = S_REPORT;
        end
      end
      S_REPORT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // cell command, new length and status of the accepted beat
  always_comb begin
    cmd     = '{op: CELL_HOLD, idx: '0};
    len_nxt = len_r;
    stat    = ST_DONE;
    if (state_r == S_SCAN) begin
      cmd.op = CELL_ROTATE;
    end
    if (in_fire) begin
      case (op)
        OP_CLEAR: len_nxt = '0;
        OP_INS_FRONT: begin
          if (full) begin
            stat = ST_FULL;
          end else begin
            cmd     = '{op: CELL_INSERT, idx: '0};
            len_nxt = len_r + CNT_W'(1);
          end
        end
        OP_INS_AT: begin
          if (full) begin
            stat = ST_FULL;
          end else if (in_ch.position == '0 || pos_x > len_x + (CNT_W+1)'(1)) begin
            stat = ST_BADPOS;
          end else begin
            cmd     = '{op: CELL_INSERT, idx: MAX_CNT_W'(pos_m1)};
            len_nxt = len_r + CNT_W'(1);
          end
        end
        OP_INS_BACK: begin
          if (full) begin
            stat = ST_FULL;
          end else begin
            cmd     = '{op: CELL_INSERT, idx: MAX_CNT_W'(len_r)};
            len_nxt = len_r + CNT_W'(1);
          end
        end
        OP_REMOVE: begin
          if (in_ch.position == '0 || pos_x > len_x) begin
            stat = ST_BADPOS;
          end else begin
            cmd     = '{op: CELL_REMOVE, idx: MAX_CNT_W'(pos_m1)};
            len_nxt = len_r - CNT_W'(1);
          end
        end
        default: len_nxt = len_r;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      if (in_fire) begin
        hit_r <= 1'b0;
      end else if (match) begin
        hit_r <= 1'b1;
      end
      if (in_fire && op != OP_FIND) begin
        out_valid_r <= 1'b1;
      end else if (state_r == S_REPORT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scan and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r  <= $unsigned(in_ch.key);
      step_r <= '0;
    end else if (state_r == S_SCAN) begin
      step_r <= step_r + STEP_W'(1);
    end
    if (match) begin
      hpos_r <= CNT_W'(step_r) + CNT_W'(1);
      hpay_r <= head_ent.payload;
    end
    if (in_fire && op != OP_FIND) begin
      out_status_r <= stat;
      out_found_r  <= 1'b0;
      out_fpos_r   <= '0;
      out_fpay_r   <= '0;
      out_cnt_r    <= len_nxt;
    end else if (state_r == S_REPORT && out_free) begin
      out_status_r <= ST_DONE;
      out_found_r  <= hit_r;
      out_fpos_r   <= hit_r ? hpos_r : '0;
      out_fpay_r   <= hit_r ? hpay_r : '0;
      out_cnt_r    <= len_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.found          = out_found_r;
  assign out_ch.found_position = out_fpos_r;
  assign out_ch.found_payload  = out_fpay_r;
  assign out_ch.entry_count    = out_cnt_r;

endmodule : sle_ctrl
`default_nettype wire

// File: hdl/sequential_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sequential_list_engine: ordered list of key/payload entries
// A row of LIST_DEPTH cells holds the list in logical order; a controller
// drives shifts for insert and remove and a full rotation for find.
// ----------------------------------------------------------------------------
// Each input beat carries one operation and produces exactly one result
// beat. Clear, the three inserts, remove and unknown opcodes complete at the
// edge that accepts them: for an insert or a remove every cell at or beyond
// the target position shifts in parallel toward or away from it, and the
// result is registered at the same edge. Find rotates the whole row past the
// head cell, one entry per cycle: the block scans every slot in S_SCAN,
// then in S_REPORT posts the result into the output register once it is
// empty or drains, and takes the next beat in S_IDLE under the same condition.
// Cells are not reset; only slots below the current count are ever read.
module sequential_list_engine #(
  parameter int LIST_DEPTH = sle_pkg::LIST_DEPTH_DEF,
  parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
  input  wire          clk,
  input  wire          rst_n,
  sle_in_if.sink       in_ch,
  sle_out_if.source    out_ch
);
  import sle_pkg::*;

  cell_cmd_t  cmd;
  entry_t     new_ent;
  entry_t     ent [LIST_DEPTH];

  assign new_ent = '{payload: in_ch.payload, key: $unsigned(in_ch.key)};

  // sequencer
  sle_ctrl #(
    .LIST_DEPTH (LIST_DEPTH),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .head_ent (ent[0]),
    .cmd      (cmd)
  );

  // row of list cells, last one wraps to the head for rotation
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;

    if (g == 0) begin : g_first
      assign left_ent = ent[0];
    end else begin : g_mid_l
      assign left_ent = ent[g-1];
    end

    if (g == LIST_DEPTH - 1) begin : g_last
      assign right_ent = ent[0];
    end else begin : g_mid_r
      assign right_ent = ent[g+1];
    end

    sle_cell #(
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .new_ent   (new_ent),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ent       (ent[g])
    );
  end

endmodule : sequential_list_engine
`default_nettype wire

// File: test/sle_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_list_checker: scoreboard for the sequential list engine
// Watches both channels, keeps a shadow copy of the list, predicts one
// result per accepted command beat and compares every result beat with it.
// ----------------------------------------------------------------------------
module sle_list_checker #(
  parameter int LIST_DEPTH = sle_pkg::LIST_DEPTH_DEF,
  parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
  input  logic clk,
  input  logic rst_n,
  sle_in_if    cmd_mon,
  sle_out_if   rsp_mon,
  output int   fail_count,
  output int   pending
);
  import sle_pkg::*;

  typedef struct packed {
    status_t             status;
    logic                found;
    logic [CNT_W-1:0]    found_position;
    logic [31:0]         found_payload;
    logic [CNT_W-1:0]    entry_count;
  } list_result_t;

  // shadow list in logical order, head at slot 0
  entry_t       shadow_slots [LIST_DEPTH];
  int           shadow_len;
  list_result_t expected_results [$];

  // open a gap at logical index idx and drop the entry in
  function automatic void shadow_insert(int idx, entry_t ent);
    for (int i = shadow_len; i > idx; i--) shadow_slots[i] = shadow_slots[i - 1];
    shadow_slots[idx] = ent;
    shadow_len++;
  endfunction

  // apply one command to the shadow list and return the result it should give
  function automatic list_result_t predict_list_op(logic [2:0] op_code,
                                                   logic [CNT_W-1:0] pos,
                                                   logic [31:0] key,
                                                   logic [31:0] payload);
    list_result_t res;
    entry_t       ent;
    logic         is_full;
    res         = '0;
    res.status  = ST_DONE;
    ent.key     = key;
    ent.payload = payload;
    is_full     = (shadow_len >= LIST_DEPTH);
    case (op_t'(op_code))
      OP_CLEAR: shadow_len = 0;
      OP_INS_FRONT: begin
        if (is_full) res.status = ST_FULL;
        else shadow_insert(0, ent);
      end
      OP_INS_AT: begin
        // full wins over a bad position
        if (is_full) res.status = ST_FULL;
        else if (pos == 0 || int'(pos) > shadow_len + 1) res.status = ST_BADPOS;
        else shadow_insert(int'(pos) - 1, ent);
      end
      OP_INS_BACK: begin
        if (is_full) res.status = ST_FULL;
        else shadow_insert(shadow_len, ent);
      end
      OP_REMOVE: begin
        if (pos == 0 || int'(pos) > shadow_len) res.status = ST_BADPOS;
        else begin
          for (int i = int'(pos) - 1; i + 1 < shadow_len; i++)
            shadow_slots[i] = shadow_slots[i + 1];
          shadow_len--;
        end
      end
      OP_FIND: begin
        // first match from the head
        for (int i = 0; i < shadow_len; i++) begin
          if (!res.found && shadow_slots[i].key == key) begin
            res.found          = 1'b1;
            res.found_position = CNT_W'(i + 1);
            res.found_payload  = shadow_slots[i].payload;
          end
        end
      end
      default: ;  // reserved opcodes leave the list alone
    endcase
    res.entry_count = CNT_W'(shadow_len);
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // result beats are matched before this edge's command beat is predicted
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      shadow_len = 0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no command outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(rsp_mon.status));
          check_field("found", 32'(want.found), 32'(rsp_mon.found));
          check_field("found_position", 32'(want.found_position),
                      32'(rsp_mon.found_position));
          check_field("found_payload", want.found_payload, rsp_mon.found_payload);
          check_field("entry_count", 32'(want.entry_count), 32'(rsp_mon.entry_count));
        end
      end
      if (cmd_mon.valid && cmd_mon.ready)
        expected_results.push_back(predict_list_op(cmd_mon.operation, cmd_mon.position,
                                                   cmd_mon.key, cmd_mon.payload));
    end
    pending = expected_results.size();
  end

endmodule : sle_list_checker

// File: test/tb_sequential_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sequential_list_engine: testbench of the sequential list engine
// Drives a directed pass over empty, full and out-of-range lists, then a
// long random run that swings the list between empty and full, with bursty
// command traffic and a stalling result sink; the checker scores results.
// ----------------------------------------------------------------------------
module tb_sequential_list_engine;
  import sle_pkg::*;

  localparam int LIST_DEPTH   = sle_pkg::LIST_DEPTH_DEF;
  localparam int CNT_W        = $clog2(LIST_DEPTH + 1);
  localparam int RANDOM_CMDS  = 1030;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
  // opcodes the block must ignore
  localparam logic [2:0] OP_RESERVED_A = 3'd6;
  localparam logic [2:0] OP_RESERVED_B = 3'd7;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_TIGHT} rx_mode_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     cmd_fire;
  int       fail_count;
  int       pending;
  int       burst_left;
  int       idle_cycles;
  int       rx_phase;
  rx_mode_t rx_mode;

  sle_in_if  #(.CNT_W(CNT_W)) in_ch ();
  sle_out_if #(.CNT_W(CNT_W)) out_ch ();

  sequential_list_engine #(.LIST_DEPTH(LIST_DEPTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sle_list_checker #(.LIST_DEPTH(LIST_DEPTH), .CNT_W(CNT_W)) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_mon    (in_ch),
    .rsp_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  // command beat taken at the last rising edge
  always @(posedge clk) cmd_fire <= rst_n && in_ch.valid && in_ch.ready;

  // result sink: open, coin-flip and tight stretches
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_phase     <= 0;
      rx_mode      <= RX_OPEN;
    end else begin
      case (rx_mode)
        RX_OPEN:  out_ch.ready <= 1'b1;
        RX_COIN:  out_ch.ready <= 1'($urandom_range(0, 1));
        default:  out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
      if (rx_phase == 0) begin
        rx_phase <= $urandom_range(20, 90);
        rx_mode  <= rx_mode_t'($urandom_range(0, 2));
      end else begin
        rx_phase <= rx_phase - 1;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_sequential_list_engine NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one command beat, entered and left at a falling edge; bursts with gaps
  task automatic send_cmd(input logic [2:0] op, input logic [CNT_W-1:0] pos,
                          input logic [31:0] key, input logic [31:0] payload);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.position  <= pos;
    in_ch.key       <= key;
    in_ch.payload   <= payload;
    do @(negedge clk); while (!cmd_fire);
  endtask

  // hold off until every outstanding result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [31:0] key_pool [8];
    logic [2:0]  op;
    logic [CNT_W-1:0] pos;
    logic [31:0] key;
    logic [31:0] payload;
    int          sent;
    int          pick;
    bit          growing;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = '0;
    in_ch.position  = '0;
    in_ch.key       = '0;
    in_ch.payload   = '0;
    burst_left      = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty list, edge positions, duplicates, full list, clear
    send_cmd(OP_FIND, 1, 32'h0, 32'h0);
    send_cmd(OP_REMOVE, 1, 32'h0, 32'h0);
    send_cmd(OP_INS_AT, 0, 32'h1, 32'h1);
    send_cmd(OP_INS_AT, 2, 32'h2, 32'h2);
    send_cmd(OP_INS_AT, 1, 32'h8000_0000, 32'h0);
    send_cmd(OP_INS_FRONT, 1, 32'h7fff_ffff, 32'hffff_ffff);
    send_cmd(OP_INS_BACK, 0, 32'h0, 32'h5555_5555);
    send_cmd(OP_INS_AT, 4, 32'hffff_ffff, 32'haaaa_aaaa);
    send_cmd(OP_INS_AT, 2, 32'h0, 32'h1234_5678);
    send_cmd(OP_FIND, 0, 32'h0, 32'h0);
    send_cmd(OP_FIND, 0, 32'h8000_0000, 32'h0);
    send_cmd(OP_FIND, 0, 32'h0001_2345, 32'h0);
    send_cmd(OP_REMOVE, 31, 32'h0, 32'h0);
    send_cmd(OP_REMOVE, 6, 32'h0, 32'h0);
    send_cmd(OP_RESERVED_A, 1, 32'h0, 32'h0);
    send_cmd(OP_RESERVED_B, 1, 32'h0, 32'h0);
    for (int k = 0; k < LIST_DEPTH - 5; k++)
      send_cmd(OP_INS_BACK, 0, 32'h100 + k, $urandom);
    send_cmd(OP_INS_FRONT, 1, 32'h9, 32'h9);
    send_cmd(OP_INS_AT, 0, 32'h9, 32'h9);
    send_cmd(OP_INS_BACK, 1, 32'h9, 32'h9);
    send_cmd(OP_FIND, 0, 32'hffff_ffff, 32'h0);
    send_cmd(OP_REMOVE, LIST_DEPTH, 32'h0, 32'h0);
    send_cmd(OP_REMOVE, 1, 32'h0, 32'h0);
    send_cmd(OP_INS_AT, 16, 32'h3, 32'h3);
    send_cmd(OP_CLEAR, 0, 32'h0, 32'h0);
    send_cmd(OP_FIND, 0, 32'h0, 32'h0);
    send_cmd(OP_REMOVE, 1, 32'h0, 32'h0);
    wait_drained();

    // small key pool so finds hit and keys repeat
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0;
    key_pool[3] = 32'hffff_ffff;
    for (int k = 4; k < 8; k++) key_pool[k] = $urandom;

    // random: swing between growing and shrinking so full and empty recur
    sent    = 0;
    growing = 1'b1;
    while (sent < RANDOM_CMDS) begin
      if ($urandom_range(0, 29) == 0) growing = ~growing;
      pick = $urandom_range(0, 99);
      if (pick < 2) op = OP_CLEAR;
      else if (pick < 5) op = ($urandom_range(0, 1) == 0) ? OP_RESERVED_A : OP_RESERVED_B;
      else if (pick < 30) op = OP_FIND;
      else if (growing) begin
        if (pick < 50) op = OP_INS_FRONT;
        else if (pick < 70) op = OP_INS_AT;
        else if (pick < 90) op = OP_INS_BACK;
        else op = OP_REMOVE;
      end else begin
        if (pick < 38) op = OP_INS_FRONT;
        else if (pick < 46) op = OP_INS_AT;
        else if (pick < 54) op = OP_INS_BACK;
        else op = OP_REMOVE;
      end

      pick = $urandom_range(0, 99);
      if (pick < 80) pos = CNT_W'($urandom_range(1, LIST_DEPTH + 1));
      else if (pick < 95) pos = CNT_W'($urandom);
      else pos = '0;

      key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 7)] : $urandom;
      pick = $urandom_range(0, 19);
      if (pick == 0) payload = 32'h0;
      else if (pick == 1) payload = 32'hffff_ffff;
      else payload = $urandom;

      send_cmd(op, pos, key, payload);
      if (op != OP_RESERVED_A && op != OP_RESERVED_B) sent++;
      if (sent % 250 == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb_sequential_list_engine OK");
    else
      $display("tb_sequential_list_engine NOT OK");
    $finish;
  end

endmodule : tb_sequential_list_engine
